FILE: rtl/npc_pkg.sv
`timescale 1ns / 1ps
package npc_pkg;

  localparam int COORD_W       = 16;
  localparam int NUM_AXES      = 3;
  localparam int SQ_W          = 2 * COORD_W;
  localparam int DIST_W        = SQ_W + 2;
  localparam int THR_W         = 36;
  localparam int CFG_CNT_W     = 11;
  localparam int IDX_W         = 10;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 36;
  localparam int MAX_POINTS_DEF = 1024;

  localparam logic [THR_W-1:0]     THR_RESET = THR_W'(4096);
  localparam logic [CFG_CNT_W-1:0] CNT_RESET = '0;

  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT     = 2'd1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] point_t;

  typedef struct packed {
    logic             cmd;
    logic [IDX_W-1:0] point_index;
    coord_t           coord_x;
    coord_t           coord_y;
    coord_t           coord_z;
  } in_t;

  typedef struct packed {
    logic              found;
    logic [IDX_W-1:0]  match_index;
    logic [DIST_W-1:0] distance_sq;
    coord_t            match_x;
    coord_t            match_y;
    coord_t            match_z;
    coord_t            source_x;
    coord_t            source_y;
    coord_t            source_z;
  } out_t;

  // token passed along the distance chain
  typedef struct packed {
    logic              valid;
    point_t            pt;
    logic [DIST_W-1:0] sum;
  } tok_t;

endpackage

FILE: rtl/npc_cell.sv
`timescale 1ns / 1ps
module npc_cell #(
  parameter int SLOT_W = 10
) (
  input  logic                clk,
  input  logic                rst,
  input  npc_pkg::coord_t     src_coord,
  input  npc_pkg::tok_t       tok_in,
  input  logic [SLOT_W-1:0]   slot_in,
  output npc_pkg::tok_t       tok_out,
  output logic [SLOT_W-1:0]   slot_out
);
  import npc_pkg::*;

  logic signed [COORD_W:0] diff;
  logic [COORD_W-1:0]      mag;
  logic [SQ_W-1:0]         sq;

  // works on axis 0 of the token, then rotates the point for the next cell
  always_comb begin
    diff = $signed({tok_in.pt[0][COORD_W-1], tok_in.pt[0]})
         - $signed({src_coord[COORD_W-1], src_coord});
    mag  = diff[COORD_W] ? COORD_W'(-diff) : diff[COORD_W-1:0];
    sq   = mag * mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.pt[0] <= tok_in.pt[1];
    tok_out.pt[1] <= tok_in.pt[2];
    tok_out.pt[2] <= tok_in.pt[0];
    tok_out.sum   <= tok_in.sum + DIST_W'(sq);
    slot_out      <= slot_in;
  end

endmodule

FILE: rtl/npc_min.sv
`timescale 1ns / 1ps
module npc_min #(
  parameter int SLOT_W = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  npc_pkg::tok_t                 tok,
  input  logic [SLOT_W-1:0]             slot,
  output logic                          have,
  output logic [npc_pkg::DIST_W-1:0]    best_dist,
  output logic [SLOT_W-1:0]             best_slot,
  output npc_pkg::point_t               best_pt
);
  import npc_pkg::*;

  logic take;

  // strict compare: earlier slot keeps a tie
  assign take = tok.valid && (!have || (tok.sum < best_dist));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (clear) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_dist <= tok.sum;
      best_slot <= slot;
      best_pt   <= tok.pt;
    end
  end

endmodule

FILE: rtl/nearest_point_correspondence.sv
`timescale 1ns / 1ps
// Load: busy stays low, next item may follow at once.
// Query: busy while N points are scanned, N = min(target_count, MAX_POINTS);
//   the result strobe (done) comes in the same cycle that busy falls. The scan reads
//   one point per cycle from the target store; a new query is taken once busy falls.
// Reset (rst, synchronous): clears control, threshold to 4096, count to 0;
//   store contents undefined until loaded. Receiver cannot stall; done is one cycle.
module nearest_point_correspondence #(
  parameter int MAX_POINTS = npc_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  npc_pkg::in_t                     item,
  output logic                             done,
  output npc_pkg::out_t                    result,
  input  logic                             cfg_we,
  input  logic [npc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [npc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import npc_pkg::*;

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]           state;
  logic [THR_W-1:0]     threshold;
  logic [CFG_CNT_W-1:0] target_count;
  logic [CNT_W-1:0]     scan_count;
  logic [CNT_W-1:0]     scan_slot;
  coord_t               src_pt [NUM_AXES];

  point_t               mem [MAX_POINTS];
  point_t               rd_data;
  logic                 rd_valid;
  logic [ADDR_W-1:0]    rd_slot;
  logic                 rd_en;

  tok_t                 chain_tok [NUM_AXES+1];
  logic [ADDR_W-1:0]    chain_slot [NUM_AXES+1];

  logic                 best_have;
  logic [DIST_W-1:0]    best_dist;
  logic [ADDR_W-1:0]    best_slot;
  point_t               best_pt;

  logic                 accept;
  logic                 query_go;
  logic                 pipe_empty;
  logic                 finish;
  logic                 found;
  point_t               load_pt;

  assign accept   = start && !busy;
  assign query_go = accept && (item.cmd == CMD_QUERY);
  assign busy     = (state != ST_IDLE);
  assign rd_en    = (state == ST_SCAN) && (scan_slot != scan_count);
  assign load_pt  = '{item.coord_z, item.coord_y, item.coord_x};

  always_comb begin
    pipe_empty = !rd_valid;
    for (int i = 1; i <= NUM_AXES; i++) begin
      pipe_empty = pipe_empty && !chain_tok[i].valid;
    end
  end

  assign finish = (state == ST_DRAIN) && pipe_empty;
  assign found  = best_have && ({{(THR_W-DIST_W){1'b0}}, best_dist} <= threshold);

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THR_RESET;
      target_count <= CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD: threshold    <= cfg_data[THR_W-1:0];
        REG_COUNT:     target_count <= cfg_data[CFG_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_slot <= '0;
      rd_valid  <= 1'b0;
      done      <= 1'b0;
    end else begin
      rd_valid <= rd_en;
      done     <= finish;
      unique case (state)
        ST_IDLE: begin
          if (query_go) begin
            state     <= ST_SCAN;
            scan_slot <= '0;
          end
        end
        ST_SCAN: begin
          if (rd_en) begin
            scan_slot <= scan_slot + CNT_W'(1);
          end else begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (pipe_empty) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (query_go) begin
      if (32'(target_count) > MAX_POINTS) begin
        scan_count <= CNT_W'(MAX_POINTS);
      end else begin
        scan_count <= CNT_W'(target_count);
      end
      src_pt[0] <= item.coord_x;
      src_pt[1] <= item.coord_y;
      src_pt[2] <= item.coord_z;
    end
  end

  // target store
  always_ff @(posedge clk) begin
    if (accept && (item.cmd == CMD_LOAD) && (32'(item.point_index) < MAX_POINTS)) begin
      mem[ADDR_W'(item.point_index)] <= load_pt;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[scan_slot[ADDR_W-1:0]];
      rd_slot <= scan_slot[ADDR_W-1:0];
    end
  end

  always_comb begin
    chain_tok[0].valid = rd_valid;
    chain_tok[0].pt    = rd_data;
    chain_tok[0].sum   = '0;
    chain_slot[0]      = rd_slot;
  end

  for (genvar g = 0; g < NUM_AXES; g++) begin : g_cell
    npc_cell #(
      .SLOT_W (ADDR_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .src_coord (src_pt[g]),
      .tok_in    (chain_tok[g]),
      .slot_in   (chain_slot[g]),
      .tok_out   (chain_tok[g+1]),
      .slot_out  (chain_slot[g+1])
    );
  end

  npc_min #(
    .SLOT_W (ADDR_W)
  ) u_min (
    .clk       (clk),
    .rst       (rst),
    .clear     (query_go),
    .tok       (chain_tok[NUM_AXES]),
    .slot      (chain_slot[NUM_AXES]),
    .have      (best_have),
    .best_dist (best_dist),
    .best_slot (best_slot),
    .best_pt   (best_pt)
  );

  // result register
  always_ff @(posedge clk) begin
    if (finish) begin
      result.found    <= found;
      result.source_x <= src_pt[0];
      result.source_y <= src_pt[1];
      result.source_z <= src_pt[2];
      if (found) begin
        result.match_index <= IDX_W'(best_slot);
        result.distance_sq <= best_dist;
        result.match_x     <= best_pt[0];
        result.match_y     <= best_pt[1];
        result.match_z     <= best_pt[2];
      end else begin
        result.match_index <= '0;
        result.distance_sq <= '0;
        result.match_x     <= '0;
        result.match_y     <= '0;
        result.match_z     <= '0;
      end
    end
  end

endmodule

FILE: rtl/npc_checker.sv
`timescale 1ns / 1ps
module npc_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input npc_pkg::in_t                    item,
  input logic                            done,
  input npc_pkg::out_t                   result
);
  import npc_pkg::*;

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without a preceding search");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_QUERY) |=> busy)
    else $error("query transfer did not start a search");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.cmd == CMD_LOAD) |=> (!busy && !done))
    else $error("load transfer caused activity");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.match_index == '0 && result.distance_sq == '0))
    else $error("miss result carries match fields");

endmodule

bind nearest_point_correspondence npc_checker u_npc_checker (.*);

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import npc_pkg::*;

  localparam int SLOTS        = MAX_POINTS_DEF;
  localparam int RANDOM_ITEMS = 580;

  // indexes past the register list, expected to be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  in_t                   item;
  logic                  done;
  out_t                  result;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  point_t               target_mem [SLOTS];
  logic [THR_W-1:0]     thr_shadow;
  logic [CFG_CNT_W-1:0] count_shadow;
  out_t                 pending_matches [$];

  int mismatches   = 0;
  int loads_sent   = 0;
  int queries_sent = 0;
  int hits_seen    = 0;
  bit idle_on      = 1'b1;

  nearest_point_correspondence dut (
    .clk,
    .rst,
    .start,
    .busy,
    .item,
    .done,
    .result,
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #100_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [63:0] sq_dist(point_t a, point_t b);
    logic [63:0] acc;
    longint d;
    acc = '0;
    for (int k = 0; k < NUM_AXES; k++) begin
      d = longint'(signed'(a[k])) - longint'(signed'(b[k]));
      acc += d * d;
    end
    return acc;
  endfunction

  function automatic out_t nearest_target(in_t q);
    out_t r;
    point_t src;
    logic [63:0] best;
    logic [63:0] d;
    int n;
    int best_k;
    src = {q.coord_x, q.coord_y, q.coord_z};
    n = (count_shadow > SLOTS) ? SLOTS : int'(count_shadow);
    best = '1;
    best_k = 0;
    for (int k = 0; k < n; k++) begin
      d = sq_dist(src, target_mem[k]);
      if (d < best) begin
        best = d;
        best_k = k;
      end
    end
    r = '0;
    if (n > 0 && best <= thr_shadow) begin
      r.found       = 1'b1;
      r.match_index = IDX_W'(best_k);
      r.distance_sq = best[DIST_W-1:0];
      r.match_x     = target_mem[best_k][2];
      r.match_y     = target_mem[best_k][1];
      r.match_z     = target_mem[best_k][0];
    end
    r.source_x = q.coord_x;
    r.source_y = q.coord_y;
    r.source_z = q.coord_z;
    return r;
  endfunction

  function automatic point_t pt(coord_t x, coord_t y, coord_t z);
    return {x, y, z};
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0: return coord_t'(-32768);
      1: return coord_t'(32767);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic point_t rand_point();
    return {rand_coord(), rand_coord(), rand_coord()};
  endfunction

  function automatic point_t jitter_point(point_t p, int spread);
    point_t r;
    for (int k = 0; k < NUM_AXES; k++)
      r[k] = coord_t'(int'(signed'(p[k])) + int'($urandom_range(0, 2 * spread)) - spread);
    return r;
  endfunction

  function automatic in_t load_item(int slot, point_t p);
    in_t it;
    it.cmd         = CMD_LOAD;
    it.point_index = IDX_W'(slot);
    it.coord_x     = p[2];
    it.coord_y     = p[1];
    it.coord_z     = p[0];
    return it;
  endfunction

  function automatic in_t query_item(point_t p);
    in_t it;
    it.cmd         = CMD_QUERY;
    it.point_index = IDX_W'($urandom);
    it.coord_x     = p[2];
    it.coord_y     = p[1];
    it.coord_z     = p[0];
    return it;
  endfunction

  // query around a loaded slot below n
  function automatic in_t near_query(int n, int spread);
    return query_item(jitter_point(target_mem[$urandom_range(0, n - 1)], spread));
  endfunction

  function automatic logic [THR_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return THR_RESET;
      3: return THR_W'($urandom_range(0, 65535));
      4: return THR_W'($urandom_range(0, 1 << 22));
      default: return {4'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic send_item(input in_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk) start <= 1'b0;
      repeat ($urandom_range(0, 16)) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
    if (it.cmd == CMD_QUERY) begin
      pending_matches = {pending_matches, nearest_target(it)};
      queries_sent++;
    end else begin
      target_mem[it.point_index] = {it.coord_x, it.coord_y, it.coord_z};
      loads_sent++;
    end
  endtask

  task automatic drain_block();
    @(negedge clk) start <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_THRESHOLD)
      thr_shadow = val[THR_W-1:0];
    else if (idx == REG_COUNT)
      count_shadow = val[CFG_CNT_W-1:0];
  endtask

  task automatic check_field(input string tag, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %0h, got %0h", tag, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    out_t want;
    if (!rst && done === 1'b1) begin
      if (pending_matches.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result with no query outstanding: %h", result);
      end else begin
        want = pending_matches.pop_front();
        if (want.found)
          hits_seen++;
        check_field("found",       want.found,       result.found);
        check_field("match_index", want.match_index, result.match_index);
        check_field("distance_sq", want.distance_sq, result.distance_sq);
        check_field("match_x",     want.match_x,     result.match_x);
        check_field("match_y",     want.match_y,     result.match_y);
        check_field("match_z",     want.match_z,     result.match_z);
        check_field("source_x",    want.source_x,    result.source_x);
        check_field("source_y",    want.source_y,    result.source_y);
        check_field("source_z",    want.source_z,    result.source_z);
      end
    end
  end

  // count is zero out of reset
  task automatic test_empty_search();
    send_item(query_item(pt(32767, -32768, 0)));
    send_item(query_item(pt(0, 0, 0)));
    drain_block();
  endtask

  task automatic test_threshold_edges();
    send_item(load_item(0, pt(-32768, -32768, -32768)));
    send_item(load_item(1, pt(32767, 32767, 32767)));
    send_item(load_item(2, pt(0, 0, 0)));
    send_item(load_item(3, pt(16'sh0100, -16'sh0100, 16'sh0080)));
    send_item(load_item(4, pt(0, 0, 0)));
    send_item(load_item(5, pt(16'sh1234, 16'sh5678, -16'sh0F0F)));
    drain_block();
    write_reg(REG_COUNT, CFG_DATA_W'(6));
    send_item(query_item(pt(0, 0, 0)));              // tie, lower slot wins
    send_item(query_item(pt(16'sh0040, 0, 0)));      // exactly at threshold
    send_item(query_item(pt(16'sh0041, 0, 0)));      // just past threshold
    send_item(query_item(pt(16'sh0100, -16'sh0100, 16'sh0080)));
    send_item(query_item(pt(16'sh1235, 16'sh5679, -16'sh0F0E)));
    send_item(query_item(pt(32767, 32767, 32767)));
    send_item(query_item(pt(-32768, -32768, -32768)));
    drain_block();
    write_reg(REG_THRESHOLD, '0);
    send_item(query_item(pt(0, 0, 0)));
    send_item(query_item(pt(0, 0, 1)));
    drain_block();
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    send_item(query_item(pt(0, 0, 1)));
    drain_block();
    write_reg(REG_THRESHOLD, '1);
    write_reg(REG_COUNT, CFG_DATA_W'(1));
    send_item(query_item(pt(32767, 32767, 32767)));  // largest distance
    drain_block();
    write_reg(REG_COUNT, {25'h1555555, 11'd2});
    send_item(query_item(pt(0, 0, 0)));
    drain_block();
  endtask

  task automatic test_full_store();
    int order [SLOTS];
    int j;
    int tmp;
    for (int k = 0; k < SLOTS; k++)
      order[k] = k;
    for (int k = SLOTS - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = order[k];
      order[k] = order[j];
      order[j] = tmp;
    end
    for (int k = 0; k < SLOTS; k++)
      send_item(load_item(order[k], rand_point()));
    drain_block();
    write_reg(REG_COUNT, CFG_DATA_W'(SLOTS));
    write_reg(REG_THRESHOLD, '1);
    send_item(query_item(rand_point()));
    send_item(near_query(SLOTS, 0));
    send_item(near_query(SLOTS, 40));
    drain_block();
    write_reg(REG_COUNT, CFG_DATA_W'(2047));
    write_reg(REG_THRESHOLD, THR_RESET);
    send_item(near_query(SLOTS, 0));
    send_item(near_query(SLOTS, 30));
    send_item(query_item(rand_point()));
    drain_block();
  endtask

  task automatic test_random_traffic();
    int issued;
    int phase_len;
    int n;
    int slot;
    issued = 0;
    while (issued < RANDOM_ITEMS) begin
      drain_block();
      idle_on = (issued < RANDOM_ITEMS * 3 / 4) && ($urandom_range(0, 3) != 0);
      write_reg(REG_THRESHOLD, pick_threshold());
      case ($urandom_range(0, 9))
        0: write_reg(REG_COUNT, '0);
        1: write_reg(REG_COUNT, CFG_DATA_W'(SLOTS));
        2: write_reg(REG_COUNT, CFG_DATA_W'($urandom_range(SLOTS + 1, 2047)));
        default: write_reg(REG_COUNT, CFG_DATA_W'($urandom_range(1, 48)));
      endcase
      n = (count_shadow > SLOTS) ? SLOTS : int'(count_shadow);
      phase_len = (n > 64) ? 8 : $urandom_range(20, 50);
      repeat (phase_len) begin
        if ($urandom_range(0, 9) < 4) begin
          slot = (n > 0 && $urandom_range(0, 3) != 0) ? $urandom_range(0, n - 1)
                                                       : $urandom_range(0, SLOTS - 1);
          if ($urandom_range(0, 1) == 0)
            send_item(load_item(slot, rand_point()));
          else
            send_item(load_item(slot, jitter_point(target_mem[$urandom_range(0, SLOTS - 1)],
                                                   $urandom_range(0, 64))));
        end else if (n == 0) begin
          send_item(query_item(rand_point()));
        end else begin
          case ($urandom_range(0, 4))
            0: send_item(near_query(n, 0));
            1: send_item(near_query(n, 16));
            2: send_item(near_query(n, 64));
            3: send_item(near_query(n, 512));
            default: send_item(query_item(rand_point()));
          endcase
        end
        issued++;
      end
    end
  endtask

  initial begin
    rst          <= 1'b1;
    start        <= 1'b0;
    item         <= '0;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    thr_shadow   = THR_RESET;
    count_shadow = CNT_RESET;
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    test_empty_search();
    test_threshold_edges();
    test_full_store();
    test_random_traffic();

    drain_block();
    repeat (64) @(posedge clk);
    $display("covered %0d point loads and %0d nearest-point queries, %0d within threshold",
             loads_sent, queries_sent, hits_seen);
    $display("field mismatches: %0d", mismatches);
    if (mismatches == 0 && pending_matches.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
